// File: design/itoaf_pkg.sv
// ----------------------------------------------------------------------------
// itoaf_pkg: shared definitions for the integer to ASCII formatter
// Holds field widths, parameter defaults, character codes and the small
// arithmetic helpers used by the formatter datapath.
// ----------------------------------------------------------------------------
package itoaf_pkg;

    localparam int MAX_RUN_DEF     = 64;
    localparam int DIGIT_STORE_DEF = 64;

    localparam int VAL_W      = 64;
    localparam int RADIX_W    = 6;
    localparam int SIZE_W     = 6;
    localparam int DIG_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int SLICE_BITS = 8;
    localparam int LEN_W      = 8;
    localparam int CNT_W      = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [DIG_W-1:0]      rem;
        logic [SLICE_BITS-1:0] quo;
    } slice_res_t;

    // Eight restoring division steps on a narrow remainder. The remainder
    // stays below the radix, so it never needs more than six bits.
    function automatic slice_res_t div_slice(input logic [DIG_W-1:0]      rem_in,
                                             input logic [SLICE_BITS-1:0] bits_in,
                                             input logic [RADIX_W-1:0]    rdx);
        logic [DIG_W:0]   part;
        logic [DIG_W-1:0] r;
        slice_res_t       res;
        r   = rem_in;
        res = '0;
        for (int j = SLICE_BITS - 1; j >= 0; j--)
        begin
            part = {r, bits_in[j]};
            if (part >= {1'b0, rdx})
            begin
                part       = part - {1'b0, rdx};
                res.quo[j] = 1'b1;
            end
            r = part[DIG_W-1:0];
        end
        res.rem = r;
        return res;
    endfunction

    // Glyph of one digit value in the selected letter case.
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIG_W-1:0] d,
                                                input logic             lc);
        logic [CHAR_W-1:0] dx;
        dx = {2'b00, d};
        if (d < 6'd10)
            return CH_ZERO + dx;
        else
            return (lc ? CH_LA : CH_UA) + dx - 8'd10;
    endfunction

endpackage

// File: design/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: printf style integer formatter, radix 2..36
// Converts one 64-bit integer into a run of ASCII characters, one per output
// word, with sign, prefix, padding and precision handling.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake          | Payload
//  --------+--------------------+---------------------------------------------
//  input   | in_valid/in_ready  | value, signed_conv, radix, min_width,
//          |                    | min_digits, left_align, zero_pad,
//          |                    | force_plus, space_sign, alt_prefix,
//          |                    | lower_case
//  output  | out_valid/out_ready| out_char, last, bad_radix, truncated
//
// The digit loop sets most of the work: the shared divide slice retires
// eight dividend bits per cycle and runs over the whole word for each digit.
// Each character sent then passes through a digit RAM read state and an
// output load state, and each segment change adds a pass through the read
// state.
// Reset clears the sequencer and the output valid; the digit RAM is not
// cleared, since only entries written for the current word are read.
// in_ready is high only while the sequencer is idle. A stalled output
// holds the character register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top #(
    parameter int MAX_RUN     = itoaf_pkg::MAX_RUN_DEF,
    parameter int DIGIT_STORE = itoaf_pkg::DIGIT_STORE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [itoaf_pkg::VAL_W-1:0]    value,
    input  logic                           signed_conv,
    input  logic [itoaf_pkg::RADIX_W-1:0]  radix,
    input  logic [itoaf_pkg::SIZE_W-1:0]   min_width,
    input  logic [itoaf_pkg::SIZE_W-1:0]   min_digits,
    input  logic                           left_align,
    input  logic                           zero_pad,
    input  logic                           force_plus,
    input  logic                           space_sign,
    input  logic                           alt_prefix,
    input  logic                           lower_case,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [itoaf_pkg::CHAR_W-1:0]   out_char,
    output logic                           last,
    output logic                           bad_radix,
    output logic                           truncated
);

    import itoaf_pkg::*;

    localparam int AW     = $clog2(DIGIT_STORE);
    localparam int ND_W   = $clog2(DIGIT_STORE + 1);
    localparam int RW     = $clog2(MAX_RUN + 1);
    localparam int SLICES = VAL_W / SLICE_BITS;
    localparam int STEP_W = $clog2(SLICES);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SLICES - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_DIV     = 3'd2;
    localparam logic [2:0] ST_LAYOUT  = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT_WR = 3'd5;

    // Text segments, in the order they are sent.
    localparam logic [2:0] SEG_LEAD  = 3'd0;
    localparam logic [2:0] SEG_SIGN  = 3'd1;
    localparam logic [2:0] SEG_PFX   = 3'd2;
    localparam logic [2:0] SEG_ZPAD  = 3'd3;
    localparam logic [2:0] SEG_PZER  = 3'd4;
    localparam logic [2:0] SEG_DIG   = 3'd5;
    localparam logic [2:0] SEG_TRAIL = 3'd6;

    // Control registers.
    logic [2:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [VAL_W-1:0]    w_reg, w_next;
    logic [DIG_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ND_W-1:0]     nd_reg, nd_next;
    logic                lost_reg, lost_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic [SIZE_W-1:0]   fw_reg, fw_next;
    logic [SIZE_W-1:0]   md_reg, md_next;
    logic                left_reg, left_next;
    logic                zp_reg, zp_next;
    logic                lower_reg, lower_next;
    logic                has_sign_reg, has_sign_next;
    logic [CHAR_W-1:0]   sign_char_reg, sign_char_next;
    logic [1:0]          plen_reg, plen_next;
    logic [CNT_W-1:0]    pad_reg, pad_next;
    logic [CNT_W-1:0]    pz_reg, pz_next;
    logic [RW-1:0]       n_reg, n_next;
    logic                trunc_reg, trunc_next;
    logic [2:0]          seg_reg, seg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RW-1:0]       emit_reg, emit_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                last_reg, last_next;
    logic                bad_reg, bad_next;
    logic                out_trunc_reg, out_trunc_next;

    // Combinational helpers.
    slice_res_t          slice;
    logic [VAL_W-1:0]    w_shift;
    logic                out_free;
    logic                neg;
    logic                radix_bad;
    logic [CNT_W-1:0]    prec;
    logic [LEN_W-1:0]    used;
    logic [LEN_W-1:0]    len;
    logic [CNT_W-1:0]    lay_pad;
    logic [2:0]          seg_adv;
    logic [CNT_W-1:0]    seg_adv_cnt;
    logic [CHAR_W-1:0]   emit_char;
    logic                emit_last;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [DIG_W-1:0]    ram_rdata;

    itoaf_ram #(
        .WIDTH (DIG_W),
        .DEPTH (DIGIT_STORE)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (slice.rem),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    assign neg       = signed_conv && value[VAL_W-1];

    // The shared divide slice consumes the top byte of the working word;
    // the quotient bits enter at the bottom, so after all slices the word
    // holds the full quotient.
    assign slice   = div_slice(rem_reg, w_reg[VAL_W-1 -: SLICE_BITS], radix_reg);
    assign w_shift = {w_reg[VAL_W-SLICE_BITS-1:0], slice.quo};

    assign ram_we    = (state_reg == ST_DIV) && (step_reg == STEP_LAST);
    assign ram_waddr = nd_reg[AW-1:0];
    // Digits go out most significant first, from the top of the store down.
    assign ram_raddr = AW'(cnt_reg - CNT_W'(1));

    // Layout: total length is the pad plus sign, prefix and precision,
    // since exactly one of the three pad segments carries the pad.
    assign prec    = (CNT_W'(md_reg) > CNT_W'(nd_reg)) ? CNT_W'(md_reg) : CNT_W'(nd_reg);
    assign used    = LEN_W'(has_sign_reg) + LEN_W'(plen_reg) + LEN_W'(prec);
    assign lay_pad = (LEN_W'(fw_reg) > used) ? CNT_W'(LEN_W'(fw_reg) - used) : '0;
    assign len     = LEN_W'(lay_pad) + used;

    // Length of the segment that follows the current one.
    assign seg_adv = seg_reg + 3'd1;
    always_comb
    begin
        unique case (seg_adv)
            SEG_LEAD:  seg_adv_cnt = (!zp_reg && !left_reg) ? pad_reg : '0;
            SEG_SIGN:  seg_adv_cnt = CNT_W'(has_sign_reg);
            SEG_PFX:   seg_adv_cnt = CNT_W'(plen_reg);
            SEG_ZPAD:  seg_adv_cnt = zp_reg ? pad_reg : '0;
            SEG_PZER:  seg_adv_cnt = pz_reg;
            SEG_DIG:   seg_adv_cnt = CNT_W'(nd_reg);
            SEG_TRAIL: seg_adv_cnt = left_reg ? pad_reg : '0;
            default:   seg_adv_cnt = '0;
        endcase
    end

    // Character of the current segment.
    always_comb
    begin
        unique case (seg_reg)
            SEG_LEAD:  emit_char = CH_SPACE;
            SEG_SIGN:  emit_char = sign_char_reg;
            SEG_PFX:   emit_char = (plen_reg == 2'd2 && cnt_reg == CNT_W'(1))
                                   ? (lower_reg ? CH_LX : CH_UX) : CH_ZERO;
            SEG_ZPAD:  emit_char = CH_ZERO;
            SEG_PZER:  emit_char = CH_ZERO;
            SEG_DIG:   emit_char = glyph(ram_rdata, lower_reg);
            SEG_TRAIL: emit_char = CH_SPACE;
            default:   emit_char = CH_NUL;
        endcase
    end

    assign emit_last = (emit_reg == n_reg - RW'(1));

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        w_next         = w_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        nd_next        = nd_reg;
        lost_next      = lost_reg;
        radix_next     = radix_reg;
        fw_next        = fw_reg;
        md_next        = md_reg;
        left_next      = left_reg;
        zp_next        = zp_reg;
        lower_next     = lower_reg;
        has_sign_next  = has_sign_reg;
        sign_char_next = sign_char_reg;
        plen_next      = plen_reg;
        pad_next       = pad_reg;
        pz_next        = pz_reg;
        n_next         = n_reg;
        trunc_next     = trunc_reg;
        seg_next       = seg_reg;
        cnt_next       = cnt_reg;
        emit_next      = emit_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        out_trunc_next = out_trunc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (radix_bad)
                    begin
                        state_next = ST_BAD;
                    end
                    else
                    begin
                        w_next         = neg ? (~value + VAL_W'(1)) : value;
                        rem_next       = '0;
                        step_next      = '0;
                        nd_next        = '0;
                        radix_next     = radix;
                        fw_next        = min_width;
                        md_next        = min_digits;
                        left_next      = left_align;
                        zp_next        = zero_pad && !left_align;
                        lower_next     = lower_case;
                        has_sign_next  = neg || force_plus || space_sign;
                        sign_char_next = neg ? CH_MINUS : (force_plus ? CH_PLUS : CH_SPACE);
                        if (alt_prefix && radix == RADIX_HEX)
                            plen_next = 2'd2;
                        else if (alt_prefix && radix == RADIX_OCT)
                            plen_next = 2'd1;
                        else
                            plen_next = 2'd0;
                        state_next     = ST_DIV;
                    end
                end
            end

            ST_BAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_NUL;
                    last_next      = 1'b1;
                    bad_next       = 1'b1;
                    out_trunc_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            ST_DIV:
            begin
                w_next    = w_shift;
                rem_next  = slice.rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    rem_next = '0;
                    nd_next  = nd_reg + ND_W'(1);
                    if (w_shift == '0 || nd_reg + ND_W'(1) >= ND_W'(DIGIT_STORE))
                    begin
                        lost_next  = (w_shift != '0);
                        state_next = ST_LAYOUT;
                    end
                end
            end

            ST_LAYOUT:
            begin
                pad_next   = lay_pad;
                pz_next    = prec - CNT_W'(nd_reg);
                n_next     = (len > LEN_W'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(len);
                trunc_next = (len > LEN_W'(MAX_RUN)) || lost_reg;
                seg_next   = SEG_LEAD;
                cnt_next   = (!zp_reg && !left_reg) ? lay_pad : '0;
                emit_next  = '0;
                state_next = ST_EMIT_RD;
            end

            ST_EMIT_RD:
            begin
                if (cnt_reg == '0)
                begin
                    seg_next = seg_adv;
                    cnt_next = seg_adv_cnt;
                end
                else
                begin
                    state_next = ST_EMIT_WR;
                end
            end

            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = emit_char;
                    last_next      = emit_last;
                    bad_next       = 1'b0;
                    out_trunc_next = emit_last && trunc_reg;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    emit_next      = emit_reg + RW'(1);
                    state_next     = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        nd_reg        <= nd_next;
        lost_reg      <= lost_next;
        radix_reg     <= radix_next;
        fw_reg        <= fw_next;
        md_reg        <= md_next;
        left_reg      <= left_next;
        zp_reg        <= zp_next;
        lower_reg     <= lower_next;
        has_sign_reg  <= has_sign_next;
        sign_char_reg <= sign_char_next;
        plen_reg      <= plen_next;
        pad_reg       <= pad_next;
        pz_reg        <= pz_next;
        n_reg         <= n_next;
        trunc_reg     <= trunc_next;
        seg_reg       <= seg_next;
        cnt_reg       <= cnt_next;
        emit_reg      <= emit_next;
        out_char_reg  <= out_char_next;
        last_reg      <= last_next;
        bad_reg       <= bad_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;
    assign truncated = out_trunc_reg;

    // A truncated word must close its run.
    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> last)
        else $error("truncated word is not the last of its run");

    // A bad radix run is one word holding a NUL character.
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_radix |-> last && out_char == CH_NUL)
        else $error("bad radix word malformed");

    // Digit writes stay inside the digit store.
    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> nd_reg < ND_W'(DIGIT_STORE))
        else $error("digit write beyond the store");

    // The sequencer only loads a new word after the previous one was taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char))
        else $error("output word overwritten while stalled");

endmodule

// File: design/itoaf_ram.sv
// ----------------------------------------------------------------------------
// itoaf_ram: generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module itoaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/sv/integer_to_ascii_formatter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formatter_text_checker: scoreboard for the integer to ASCII formatter
// Watches both channels, builds the expected character run of every accepted
// request and compares each output word, field by field, with it.
// ----------------------------------------------------------------------------
module formatter_text_checker (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [itoaf_pkg::VAL_W-1:0]    value,
    input  logic                           signed_conv,
    input  logic [itoaf_pkg::RADIX_W-1:0]  radix,
    input  logic [itoaf_pkg::SIZE_W-1:0]   min_width,
    input  logic [itoaf_pkg::SIZE_W-1:0]   min_digits,
    input  logic                           left_align,
    input  logic                           zero_pad,
    input  logic                           force_plus,
    input  logic                           space_sign,
    input  logic                           alt_prefix,
    input  logic                           lower_case,

    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [itoaf_pkg::CHAR_W-1:0]   out_char,
    input  logic                           last,
    input  logic                           bad_radix,
    input  logic                           truncated,

    output int                             fail_count,
    output int                             pending_chars,
    output int                             requests_seen,
    output int                             chars_checked,
    output int                             bad_runs,
    output int                             cut_runs
);

    import itoaf_pkg::*;

    localparam int RUN_LIMIT   = MAX_RUN_DEF;
    localparam int DIGIT_LIMIT = DIGIT_STORE_DEF;
    localparam int PRINT_LIMIT = 30;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
        logic              bad;
        logic              cut;
    } text_char_t;

    text_char_t expected_text[$];

    function automatic logic [CHAR_W-1:0] digit_char(input int d, input logic lc);
        string glyphs;
        if (lc)
            glyphs = "0123456789abcdefghijklmnopqrstuvwxyz";
        else
            glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
        return glyphs[d];
    endfunction

    // Appends the full character run that one request produces.
    task automatic predict_text(input logic [VAL_W-1:0]   val,
                                input logic               sconv,
                                input logic [RADIX_W-1:0] rdx,
                                input logic [SIZE_W-1:0]  fw,
                                input logic [SIZE_W-1:0]  md,
                                input logic               left,
                                input logic               zpad,
                                input logic               plus,
                                input logic               spc,
                                input logic               alt,
                                input logic               lc);
        logic [VAL_W-1:0]  mag;
        logic [VAL_W-1:0]  base;
        logic [CHAR_W-1:0] sign_ch;
        logic [CHAR_W-1:0] digs [0:DIGIT_LIMIT-1];
        logic [CHAR_W-1:0] line [$];
        logic              zp;
        logic              lost;
        logic              cut;
        int                nd;
        int                prec;
        int                pad;
        int                n;
        int                k;
        text_char_t        w;

        if (rdx < RADIX_MIN || rdx > RADIX_MAX)
        begin
            w.ch  = CH_NUL;
            w.fin = 1'b1;
            w.bad = 1'b1;
            w.cut = 1'b0;
            expected_text.push_back(w);
        end
        else
        begin
            zp      = zpad && !left;
            mag     = val;
            sign_ch = CH_NUL;
            if (sconv && val[VAL_W-1])
            begin
                sign_ch = CH_MINUS;
                mag     = ~val + 64'd1;
            end
            else if (plus)
                sign_ch = CH_PLUS;
            else if (spc)
                sign_ch = CH_SPACE;

            pad = int'(fw);
            if (sign_ch != CH_NUL)
                pad--;
            if (alt && rdx == RADIX_HEX)
                pad -= 2;
            else if (alt && rdx == RADIX_OCT)
                pad -= 1;

            // Digits come out least significant first.
            base = {58'd0, rdx};
            nd   = 0;
            do
            begin
                digs[nd] = digit_char(int'(mag % base), lc);
                nd++;
                mag = mag / base;
            end
            while (mag != 64'd0 && nd < DIGIT_LIMIT);
            lost = (mag != 64'd0);

            prec = (int'(md) > nd) ? int'(md) : nd;
            pad -= prec;

            if (!zp && !left)
                while (pad > 0)
                begin
                    line.push_back(CH_SPACE);
                    pad--;
                end
            if (sign_ch != CH_NUL)
                line.push_back(sign_ch);
            if (alt && rdx == RADIX_OCT)
                line.push_back(CH_ZERO);
            else if (alt && rdx == RADIX_HEX)
            begin
                line.push_back(CH_ZERO);
                line.push_back(lc ? CH_LX : CH_UX);
            end
            if (!left)
                while (pad > 0)
                begin
                    line.push_back(zp ? CH_ZERO : CH_SPACE);
                    pad--;
                end
            for (k = nd; k < prec; k++)
                line.push_back(CH_ZERO);
            for (k = nd - 1; k >= 0; k--)
                line.push_back(digs[k]);
            while (pad > 0)
            begin
                line.push_back(CH_SPACE);
                pad--;
            end

            n   = (line.size() > RUN_LIMIT) ? RUN_LIMIT : line.size();
            cut = (line.size() > RUN_LIMIT) || lost;
            for (k = 0; k < n; k++)
            begin
                w.ch  = line[k];
                w.fin = (k == n - 1);
                w.bad = 1'b0;
                w.cut = w.fin && cut;
                expected_text.push_back(w);
            end
        end
    endtask

    always @(posedge clk)
    begin : monitor
        text_char_t exp_w;
        int         errs;
        int         shown;

        errs  = 0;
        shown = fail_count;
        if (!rst_n)
        begin
            expected_text.delete();
            fail_count    <= 0;
            pending_chars <= 0;
            requests_seen <= 0;
            chars_checked <= 0;
            bad_runs      <= 0;
            cut_runs      <= 0;
        end
        else
        begin
            // Output first, so a request taken in this cycle cannot match it.
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    errs++;
                    if (shown < PRINT_LIMIT)
                        $display("%0t: unexpected output word: expected none, %s %h last %b",
                                 $time, "actual char", out_char, last);
                end
                else
                begin
                    exp_w = expected_text.pop_front();
                    if (out_char !== exp_w.ch)
                    begin
                        errs++;
                        if (shown < PRINT_LIMIT)
                            $display("%0t: out_char mismatch: expected %h, actual %h",
                                     $time, exp_w.ch, out_char);
                    end
                    if (last !== exp_w.fin)
                    begin
                        errs++;
                        if (shown < PRINT_LIMIT)
                            $display("%0t: last mismatch: expected %b, actual %b",
                                     $time, exp_w.fin, last);
                    end
                    if (bad_radix !== exp_w.bad)
                    begin
                        errs++;
                        if (shown < PRINT_LIMIT)
                            $display("%0t: bad_radix mismatch: expected %b, actual %b",
                                     $time, exp_w.bad, bad_radix);
                    end
                    if (truncated !== exp_w.cut)
                    begin
                        errs++;
                        if (shown < PRINT_LIMIT)
                            $display("%0t: truncated mismatch: expected %b, actual %b",
                                     $time, exp_w.cut, truncated);
                    end
                    chars_checked <= chars_checked + 1;
                    if (exp_w.bad)
                        bad_runs <= bad_runs + 1;
                    if (exp_w.cut)
                        cut_runs <= cut_runs + 1;
                end
            end

            if (in_valid && in_ready)
            begin
                predict_text(value, signed_conv, radix, min_width, min_digits,
                             left_align, zero_pad, force_plus, space_sign,
                             alt_prefix, lower_case);
                requests_seen <= requests_seen + 1;
            end

            fail_count    <= fail_count + errs;
            pending_chars <= expected_text.size();
        end
    end

endmodule

// File: tb/sv/integer_to_ascii_formatter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top_tb: stimulus and verdict for the formatter
// Sends directed and random formatting requests under changing idle patterns
// and a long output stall; a separate scoreboard checks every character.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top_tb;
    import itoaf_pkg::*;

    // Slowest request is 64 binary digits plus 64 output characters, each
    // of which may wait on a stalled receiver. The limit covers every
    // request being that slow several times over.
    localparam int CYCLE_LIMIT     = 2_500_000;
    localparam int HOLD_OFF_CYCLES = 1200;
    localparam int DRAIN_CYCLES    = 700;
    localparam int RANDOM_PER_PHASE = 92;

    localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    // Request channel, all driven from the stimulus process.
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [VAL_W-1:0]    value = '0;
    logic                signed_conv = 1'b0;
    logic [RADIX_W-1:0]  radix = '0;
    logic [SIZE_W-1:0]   min_width = '0;
    logic [SIZE_W-1:0]   min_digits = '0;
    logic                left_align = 1'b0;
    logic                zero_pad = 1'b0;
    logic                force_plus = 1'b0;
    logic                space_sign = 1'b0;
    logic                alt_prefix = 1'b0;
    logic                lower_case = 1'b0;

    // Character channel; out_ready comes from the receiver process.
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAR_W-1:0]   out_char;
    logic                last;
    logic                bad_radix;
    logic                truncated;

    // Idle percentages per side, and the hold-off request counters. The
    // stimulus process writes the requests, the receiver counts them off.
    int                  in_idle_pct = 0;
    int                  out_idle_pct = 0;
    int                  holds_asked = 0;
    int                  holds_done = 0;
    int                  cycle_count = 0;

    int                  fail_count;
    int                  pending_chars;
    int                  requests_seen;
    int                  chars_checked;
    int                  bad_runs;
    int                  cut_runs;

    always #5 clk = ~clk;

    integer_to_ascii_formatter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .signed_conv (signed_conv),
        .radix       (radix),
        .min_width   (min_width),
        .min_digits  (min_digits),
        .left_align  (left_align),
        .zero_pad    (zero_pad),
        .force_plus  (force_plus),
        .space_sign  (space_sign),
        .alt_prefix  (alt_prefix),
        .lower_case  (lower_case),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last        (last),
        .bad_radix   (bad_radix),
        .truncated   (truncated)
    );

    formatter_text_checker text_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .signed_conv   (signed_conv),
        .radix         (radix),
        .min_width     (min_width),
        .min_digits    (min_digits),
        .left_align    (left_align),
        .zero_pad      (zero_pad),
        .force_plus    (force_plus),
        .space_sign    (space_sign),
        .alt_prefix    (alt_prefix),
        .lower_case    (lower_case),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .last          (last),
        .bad_radix     (bad_radix),
        .truncated     (truncated),
        .fail_count    (fail_count),
        .pending_chars (pending_chars),
        .requests_seen (requests_seen),
        .chars_checked (chars_checked),
        .bad_runs      (bad_runs),
        .cut_runs      (cut_runs)
    );

    // Watchdog. A hung handshake ends the run here with the failure verdict.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d characters outstanding.",
                     cycle_count, pending_chars);
            $display("integer_to_ascii_formatter_top test failed");
            $finish;
        end
    end

    // Receiver. Normally it drops ready at random at the current idle rate.
    // When a hold-off is requested it keeps ready low for a long stretch, so
    // the formatter sits on a finished character and refuses new requests
    // while the sender keeps its word on the input.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
                out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Offers one request word. Called and returning at a rising edge. Valid
    // is lowered only for idle cycles, so back-to-back words keep it high
    // without a low/high pair of assignments in one time step.
    task automatic offer_word(input logic [VAL_W-1:0]   v,
                              input logic               sc,
                              input logic [RADIX_W-1:0] r,
                              input logic [SIZE_W-1:0]  fw,
                              input logic [SIZE_W-1:0]  md,
                              input logic               la,
                              input logic               zp,
                              input logic               fp,
                              input logic               ss,
                              input logic               ap,
                              input logic               lc);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        value       <= v;
        signed_conv <= sc;
        radix       <= r;
        min_width   <= fw;
        min_digits  <= md;
        left_align  <= la;
        zero_pad    <= zp;
        force_plus  <= fp;
        space_sign  <= ss;
        alt_prefix  <= ap;
        lower_case  <= lc;
        // in_ready read here is the value the edge sampled.
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // One random request. Values lean toward the edges of the number range,
    // radices toward the ones with prefixes, and widths mostly stay small so
    // that padding, precision and plain output all occur often.
    task automatic offer_random_word();
        logic [VAL_W-1:0]   v;
        logic [RADIX_W-1:0] r;
        logic [SIZE_W-1:0]  fw;
        logic [SIZE_W-1:0]  md;

        case ($urandom_range(7))
            0:       v = {32'd0, 32'($urandom_range(40))};
            1:       v = {$urandom, $urandom};
            2:       v = {$urandom, $urandom} >> $urandom_range(63);
            3:       v = -({32'd0, $urandom} >> $urandom_range(31));
            4:       v = MOST_NEG ^ {62'd0, 2'($urandom_range(3))};
            5:       v = ALL_ONES - {62'd0, 2'($urandom_range(3))};
            default: v = {32'd0, $urandom};
        endcase

        case ($urandom_range(9))
            0:
                if ($urandom_range(1) == 1)
                    r = 6'($urandom_range(1));
                else
                    r = 6'($urandom_range(63, 37));
            1:       r = RADIX_OCT;
            2:       r = RADIX_HEX;
            3:       r = 6'd10;
            4:       r = RADIX_MIN;
            default: r = 6'($urandom_range(36, 2));
        endcase

        if ($urandom_range(7) == 0)
            fw = 6'($urandom_range(63));
        else
            fw = 6'($urandom_range(24));

        case ($urandom_range(9)) inside
            [0:2]:   md = '0;
            3:       md = 6'($urandom_range(63));
            default: md = 6'($urandom_range(12));
        endcase

        offer_word(v, 1'($urandom_range(1)), r, fw, md,
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender idles now and then, receiver most of the time.
        in_idle_pct  <= 28;
        out_idle_pct <= 65;

        // Directed requests. Zero, with and without a minimum digit count.
        offer_word(64'd0, 1'b0, 6'd10, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(64'd0, 1'b1, 6'd10, 6'd0, 6'd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // Most negative signed value and minus one; the all-ones bits unsigned.
        offer_word(MOST_NEG, 1'b1, 6'd10, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(ALL_ONES, 1'b1, 6'd10, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(ALL_ONES, 1'b0, 6'd10, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // All 64 binary digits fit exactly; a plus sign pushes it past the run
        // length and the last character must carry the cut-off flag.
        offer_word(ALL_ONES, 1'b0, RADIX_MIN, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(ALL_ONES, 1'b0, RADIX_MIN, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        // Radices outside 2..36 at both ends.
        offer_word(64'd7, 1'b0, 6'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(64'd7, 1'b0, 6'd1, 6'd9, 6'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(64'd7, 1'b0, 6'd37, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(ALL_ONES, 1'b1, 6'd63, 6'd63, 6'd63, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        // Radix 36 in both letter cases.
        offer_word(ALL_ONES, 1'b0, RADIX_MAX, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(ALL_ONES, 1'b0, RADIX_MAX, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        // Alternate prefix in hex (both cases), octal, and radices that ignore it.
        offer_word(64'hDEAD_BEEF, 1'b0, RADIX_HEX, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        offer_word(64'hDEAD_BEEF, 1'b0, RADIX_HEX, 6'd14, 6'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        offer_word(64'o777, 1'b0, RADIX_OCT, 6'd8, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        offer_word(64'd12345, 1'b0, 6'd10, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        offer_word(64'd5, 1'b0, RADIX_MIN, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        // Plus sign, space sign, and plus winning over space.
        offer_word(64'd42, 1'b1, 6'd10, 6'd6, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        offer_word(64'd42, 1'b0, 6'd10, 6'd6, 6'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        offer_word(64'd42, 1'b0, 6'd10, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        // Left alignment overrides zero padding; precision inside a width.
        offer_word(-64'd42, 1'b1, 6'd10, 6'd12, 6'd4, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        offer_word(-64'd42, 1'b1, 6'd10, 6'd12, 6'd4, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // Widths beyond 60 are used as given; the first of these runs exceeds 64 characters.
        offer_word(64'hABC, 1'b1, RADIX_HEX, 6'd63, 6'd63, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
        offer_word(64'd9, 1'b0, 6'd10, 6'd63, 6'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);

        repeat (RANDOM_PER_PHASE) offer_random_word();

        // Phase two: the idle rates swap sides.
        in_idle_pct  <= 65;
        out_idle_pct <= 28;
        repeat (RANDOM_PER_PHASE) offer_random_word();

        // Phase three: no idling at all, opened by a long receiver stall
        // while the sender keeps offering.
        in_idle_pct  <= 0;
        out_idle_pct <= 0;
        holds_asked  <= holds_asked + 1;
        repeat (RANDOM_PER_PHASE + 8) offer_random_word();
        in_valid <= 1'b0;

        // Let the last run drain, then watch a while for stray characters.
        @(posedge clk);
        while (pending_chars != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d formatting requests, %0d output characters in all.",
                 requests_seen, chars_checked);
        $display("Runs with an invalid radix: %0d, runs cut off at the length limit: %0d.",
                 bad_runs, cut_runs);
        if (fail_count == 0)
            $display("integer_to_ascii_formatter_top test passed");
        else
            $display("integer_to_ascii_formatter_top test failed");
        $finish;
    end

endmodule
